// File: hdl/msk_pkg.sv
// ----------------------------------------------------------------------------
// msk_pkg
// Shared types and constants of the max tracking stack.
// ----------------------------------------------------------------------------
package msk_pkg;

  localparam int DATA_W        = 32;
  localparam int FILL_W        = 11;
  localparam int DEPTH_DEFAULT = 1024;

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] max_value;
    logic [FILL_W-1:0]        fill_count;
    logic                     is_empty;
    logic [1:0]               error;
  } result_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP_WAIT
  } state_t;

endpackage

// File: hdl/max_tracking_stack_top.sv
// ----------------------------------------------------------------------------
// max_tracking_stack_top
// LIFO stack of signed 32-bit values that reports its running maximum.
// ----------------------------------------------------------------------------
// Push, query, a refused command and a pop that empties the stack are taken
// while busy is low, and the result shows on the following cycle with done
// high. A pop that leaves entries behind raises busy for one cycle while the
// single RAM read port fetches the new top entry, and the result follows
// right after. The top entry and its maximum are held in registers, so a push
// never reads the RAM. Each result is marked by done, which is high for
// exactly one cycle, and the result port then holds it; the receiver cannot
// stall it. RAM contents need no clearing after reset.
// ----------------------------------------------------------------------------
module max_tracking_stack_top #(
  parameter int DEPTH = msk_pkg::DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  msk_pkg::cmd_t    cmd,
  output logic             done,
  output msk_pkg::result_t result
);

  import msk_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = 2 * DATA_W;
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  state_t state, state_next;

  logic [CW-1:0]            count, count_next;
  logic signed [DATA_W-1:0] top_val, top_val_next;
  logic signed [DATA_W-1:0] top_max, top_max_next;
  logic signed [DATA_W-1:0] pop_hold, pop_hold_next;
  logic                     done_next;
  result_t                  result_next;

  logic                     accept;
  logic                     pop_deep;
  logic                     we;
  logic                     re;
  logic [AW-1:0]            waddr;
  logic [AW-1:0]            raddr;
  logic [EW-1:0]            wdata;
  logic [EW-1:0]            rdata;
  logic signed [DATA_W-1:0] push_max;

  msk_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign accept   = start && !busy;
  assign pop_deep = (cmd.action == ACT_POP) && (count > CW'(1));
  assign push_max = ((count == '0) || (cmd.value > top_max)) ? cmd.value : top_max;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && pop_deep) begin
          state_next = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs of the state machine
  always_comb begin
    busy  = 1'b0;
    we    = 1'b0;
    re    = 1'b0;
    waddr = count[AW-1:0];
    raddr = AW'(count - CW'(2));
    wdata = {cmd.value, push_max};
    unique case (state)
      ST_IDLE: begin
        we = accept && (cmd.action == ACT_PUSH) && (count != FULL);
        re = accept && pop_deep;
      end
      ST_POP_WAIT: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    count_next   = count;
    top_val_next = top_val;
    top_max_next = top_max;
    pop_hold_next = pop_hold;
    done_next    = 1'b0;
    result_next  = result;

    if (state == ST_POP_WAIT) begin
      top_val_next             = rdata[EW-1:DATA_W];
      top_max_next             = rdata[DATA_W-1:0];
      done_next                = 1'b1;
      result_next.popped_value = pop_hold;
      result_next.top_value    = rdata[EW-1:DATA_W];
      result_next.max_value    = rdata[DATA_W-1:0];
      result_next.fill_count   = FILL_W'(count);
      result_next.is_empty     = 1'b0;
      result_next.error        = ERR_OK;
    end else if (accept) begin
      done_next                = 1'b1;
      result_next.popped_value = '0;
      result_next.error        = ERR_OK;
      priority if (cmd.action == ACT_PUSH) begin
        if (count == FULL) begin
          result_next.error = ERR_OVERFLOW;
        end else begin
          count_next   = count + CW'(1);
          top_val_next = cmd.value;
          top_max_next = push_max;
        end
      end else if (cmd.action == ACT_POP) begin
        if (count == '0) begin
          result_next.error = ERR_UNDERFLOW;
        end else begin
          count_next               = count - CW'(1);
          result_next.popped_value = top_val;
          pop_hold_next            = top_val;
          if (pop_deep) begin
            done_next = 1'b0;
          end
        end
      end else begin
        count_next = count;
      end
      result_next.fill_count = FILL_W'(count_next);
      result_next.is_empty   = (count_next == '0);
      result_next.top_value  = (count_next == '0) ? '0 : top_val_next;
      result_next.max_value  = (count_next == '0) ? '0 : top_max_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    top_val  <= top_val_next;
    top_max  <= top_max_next;
    pop_hold <= pop_hold_next;
    result   <= result_next;
  end

`ifndef SYNTH
  a_wait_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("pop wait did not finish in one cycle");

  a_fast_result: assert property (@(posedge clk) disable iff (rst)
    accept && !pop_deep |=> done)
    else $error("single-cycle command gave no result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("fill count above depth");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.action == ACT_PUSH) && (count == FULL)
      |=> done && (result.error == ERR_OVERFLOW) && (count == FULL))
    else $error("push on full stack not refused");

  a_max_order: assert property (@(posedge clk) disable iff (rst)
    done |-> result.max_value >= result.top_value)
    else $error("maximum below top entry");
`endif

endmodule

// File: hdl/msk_ram.sv
// ----------------------------------------------------------------------------
// msk_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module msk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
